### rtl/core/stt_pkg.sv
// Shared types and constants for the source text tokenizer.
`timescale 1ns / 1ps

package stt_pkg;

    // Keyword buffer size in bytes and the resulting word width
    localparam int KEYWORD_BYTES = 8;
    localparam int WORD_BITS     = 8 * KEYWORD_BYTES;

    // Command queue between the front and back parts
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Token slots carried by one command: pending flush, byte token or final word flush, end
    localparam int SLOTS = 3;

    // Token kinds (keywords take 0 through 7 in table order)
    localparam logic [4:0] KIND_IDENT   = 5'd8;
    localparam logic [4:0] KIND_NUMBER  = 5'd9;
    localparam logic [4:0] KIND_PLUS    = 5'd10;
    localparam logic [4:0] KIND_MINUS   = 5'd11;
    localparam logic [4:0] KIND_STAR    = 5'd12;
    localparam logic [4:0] KIND_SLASH   = 5'd13;
    localparam logic [4:0] KIND_EQUAL   = 5'd14;
    localparam logic [4:0] KIND_COMMA   = 5'd15;
    localparam logic [4:0] KIND_SEMI    = 5'd16;
    localparam logic [4:0] KIND_LPAREN  = 5'd17;
    localparam logic [4:0] KIND_RPAREN  = 5'd18;
    localparam logic [4:0] KIND_LBRACE  = 5'd19;
    localparam logic [4:0] KIND_RBRACE  = 5'd20;
    localparam logic [4:0] KIND_UNKNOWN = 5'd21;
    localparam logic [4:0] KIND_END     = 5'd22;

    // Characters with a role of their own
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_CR         = 8'h0D;

    // Keywords packed first byte lowest: function if while return int float bool string
    localparam logic [WORD_BITS-1:0] KW_WORDS [KEYWORD_BYTES] = '{
        64'h6E6F6974_636E7566,
        64'h00000000_00006669,
        64'h00000065_6C696877,
        64'h00006E72_75746572,
        64'h00000000_00746E69,
        64'h00000074_616F6C66,
        64'h00000000_6C6F6F62,
        64'h0000676E_69727473
    };

    // One input request
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } stt_in_t;

    // One output token
    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] line;
        logic [15:0] start_res;
        logic [15:0] length;
        logic [7:0]  char_code;
        logic        run_last;
    } stt_out_t;

    // One token slot of a command
    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] line;
        logic [15:0] start_res;
        logic [15:0] length;
        logic [7:0]  char_code;
    } stt_slot_t;

    // Command from front to back: up to three tokens in emit order
    typedef struct packed {
        logic [SLOTS-1:0]            slot_v;
        stt_slot_t [SLOTS-1:0]       slot;
    } stt_cmd_t;

    // Kind of a finished identifier or number
    function automatic logic [4:0] word_kind(
        input logic                 is_ident,
        input logic [WORD_BITS-1:0] word,
        input logic                 overflow
    );
        logic [4:0] kind;
        kind = KIND_NUMBER;
        if (is_ident) begin
            kind = KIND_IDENT;
            if (!overflow) begin
                for (int k = KEYWORD_BYTES - 1; k >= 0; k--) begin
                    if (word == KW_WORDS[k]) begin
                        kind = 5'(k);
                    end
                end
            end
        end
        return kind;
    endfunction

    // Kind of a single byte that is neither whitespace nor a word or digit
    function automatic logic [4:0] byte_kind(input logic [7:0] c);
        logic [4:0] kind;
        case (c)
            8'h2B:   kind = KIND_PLUS;
            8'h2D:   kind = KIND_MINUS;
            8'h2A:   kind = KIND_STAR;
            8'h2F:   kind = KIND_SLASH;
            8'h3D:   kind = KIND_EQUAL;
            8'h2C:   kind = KIND_COMMA;
            8'h3B:   kind = KIND_SEMI;
            8'h28:   kind = KIND_LPAREN;
            8'h29:   kind = KIND_RPAREN;
            8'h7B:   kind = KIND_LBRACE;
            8'h7D:   kind = KIND_RBRACE;
            default: kind = KIND_UNKNOWN;
        endcase
        return kind;
    endfunction

endpackage

### rtl/core/stt_front.sv
// Front part: accepts bytes, tracks token state and builds token commands.
`timescale 1ns / 1ps

module stt_front #(
    parameter int OFFSET_WIDTH = 16,
    parameter int LINE_WIDTH   = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_stall,
    input  stt_pkg::stt_in_t  src_data,
    input  logic              q_full,
    output logic              q_push,
    output stt_pkg::stt_cmd_t q_cmd
);

    typedef enum logic [1:0] {
        M_IDLE,
        M_IDENT,
        M_NUMBER
    } mode_t;

    mode_t                            mode_reg, mode_next;
    logic [OFFSET_WIDTH-1:0]          start_reg, start_next;
    logic [OFFSET_WIDTH-1:0]          len_reg, len_next;
    logic [stt_pkg::WORD_BITS-1:0]    word_reg, word_next;
    logic                             ovf_reg, ovf_next;
    logic [LINE_WIDTH-1:0]            line_reg, line_next;
    logic [OFFSET_WIDTH-1:0]          offset_reg, offset_next;

    logic       accept;
    logic [7:0] c;
    logic       is_letter, is_digit, is_space, is_word, used;

    assign src_stall = q_full;
    assign accept    = src_valid && !q_full;

    // Classify the incoming byte
    always_comb
    begin
        c         = src_data.ch;
        is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
        is_digit  = (c >= 8'h30 && c <= 8'h39);
        is_space  = (c == stt_pkg::CH_SPACE)
                    || (c >= stt_pkg::CH_TAB && c <= stt_pkg::CH_CR);
        is_word   = is_letter || is_digit || (c == stt_pkg::CH_UNDERSCORE);
        used      = (mode_reg == M_IDENT && is_word) || (mode_reg == M_NUMBER && is_digit);
    end

    // Work out next token state and the tokens this byte causes
    always_comb
    begin
        mode_next   = mode_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        word_next   = word_reg;
        ovf_next    = ovf_reg;
        line_next   = line_reg;
        offset_next = offset_reg;
        q_cmd       = '0;

        // Close a pending word on a byte that cannot extend it
        if (mode_reg != M_IDLE && !used) begin
            q_cmd.slot_v[0]           = 1'b1;
            q_cmd.slot[0].kind        = stt_pkg::word_kind(mode_reg == M_IDENT,
                                                           word_reg, ovf_reg);
            q_cmd.slot[0].line        = 16'(line_reg);
            q_cmd.slot[0].start_res   = 16'(start_reg);
            q_cmd.slot[0].length      = 16'(len_reg);
            mode_next                 = M_IDLE;
        end

        if (used) begin
            // Extend the current word
            if (mode_reg == M_IDENT) begin
                if (len_reg < OFFSET_WIDTH'(stt_pkg::KEYWORD_BYTES)) begin
                    word_next[{len_reg[2:0], 3'b000} +: 8] = c;
                end else begin
                    ovf_next = 1'b1;
                end
            end
            if (len_reg != '1) begin
                len_next = len_reg + 1'b1;
            end
        end else if (is_space) begin
            if (c == stt_pkg::CH_NEWLINE && line_reg != '1) begin
                line_next = line_reg + 1'b1;
            end
        end else if (is_letter || c == stt_pkg::CH_UNDERSCORE) begin
            mode_next  = M_IDENT;
            start_next = offset_reg;
            len_next   = OFFSET_WIDTH'(1);
            word_next  = stt_pkg::WORD_BITS'(c);
            ovf_next   = 1'b0;
        end else if (is_digit) begin
            mode_next  = M_NUMBER;
            start_next = offset_reg;
            len_next   = OFFSET_WIDTH'(1);
        end else begin
            q_cmd.slot_v[1]         = 1'b1;
            q_cmd.slot[1].kind      = stt_pkg::byte_kind(c);
            q_cmd.slot[1].line      = 16'(line_reg);
            q_cmd.slot[1].start_res = 16'(offset_reg);
            q_cmd.slot[1].length    = 16'd1;
            q_cmd.slot[1].char_code = c;
        end

        if (offset_reg != '1) begin
            offset_next = offset_reg + 1'b1;
        end

        // Flush on the final byte, add the end token, then start over
        if (src_data.last) begin
            if (mode_next != M_IDLE) begin
                q_cmd.slot_v[1]         = 1'b1;
                q_cmd.slot[1].kind      = stt_pkg::word_kind(mode_next == M_IDENT,
                                                             word_next, ovf_next);
                q_cmd.slot[1].line      = 16'(line_next);
                q_cmd.slot[1].start_res = 16'(start_next);
                q_cmd.slot[1].length    = 16'(len_next);
                q_cmd.slot[1].char_code = 8'd0;
            end
            q_cmd.slot_v[2]         = 1'b1;
            q_cmd.slot[2].kind      = stt_pkg::KIND_END;
            q_cmd.slot[2].line      = 16'(line_next);
            q_cmd.slot[2].start_res = 16'(offset_next);
            mode_next   = M_IDLE;
            start_next  = '0;
            len_next    = '0;
            word_next   = '0;
            ovf_next    = 1'b0;
            line_next   = LINE_WIDTH'(1);
            offset_next = '0;
        end

        q_push = accept && (q_cmd.slot_v != '0);
    end

    // Hold token state; advance it on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= M_IDLE;
            start_reg  <= '0;
            len_reg    <= '0;
            word_reg   <= '0;
            ovf_reg    <= 1'b0;
            line_reg   <= LINE_WIDTH'(1);
            offset_reg <= '0;
        end else if (accept) begin
            mode_reg   <= mode_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
            word_reg   <= word_next;
            ovf_reg    <= ovf_next;
            line_reg   <= line_next;
            offset_reg <= offset_next;
        end
    end

endmodule

### rtl/core/stt_queue.sv
// Short command queue between the front and back parts.
`timescale 1ns / 1ps

module stt_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  stt_pkg::stt_cmd_t           push_cmd,
    output logic                        full,
    input  logic                        pop,
    output logic                        head_valid,
    output stt_pkg::stt_cmd_t           head_cmd,
    output logic [stt_pkg::QCNT_W-1:0]  level
);

    stt_pkg::stt_cmd_t                 mem [stt_pkg::QUEUE_DEPTH];
    logic [stt_pkg::QPTR_W-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [stt_pkg::QCNT_W-1:0]        count_reg;

    assign full       = (count_reg == stt_pkg::QCNT_W'(stt_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];
    assign level      = count_reg;

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/core/stt_back.sv
// Back part: sends command tokens one per cycle unless stalled, via an output register.
`timescale 1ns / 1ps

module stt_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  stt_pkg::stt_cmd_t head_cmd,
    output logic              pop,
    output logic              tok_valid,
    input  logic              tok_stall,
    output stt_pkg::stt_out_t tok_data
);

    logic [stt_pkg::SLOTS-1:0] sent_reg, sent_next;
    logic                      out_valid_reg, out_valid_next;
    stt_pkg::stt_out_t         out_data_reg, out_data_next;

    logic [stt_pkg::SLOTS-1:0] remaining, pick;
    logic                      final_slot, load;
    stt_pkg::stt_slot_t        slot_sel;

    assign tok_valid = out_valid_reg;
    assign tok_data  = out_data_reg;

    // Pick the earliest unsent slot of the head command
    always_comb
    begin
        remaining  = head_cmd.slot_v & ~sent_reg;
        pick       = remaining & (~remaining + 1'b1);
        final_slot = (remaining == pick);
        case (pick)
            3'b001:  slot_sel = head_cmd.slot[0];
            3'b010:  slot_sel = head_cmd.slot[1];
            3'b100:  slot_sel = head_cmd.slot[2];
            default: slot_sel = head_cmd.slot[0];
        endcase
        load = head_valid && (!out_valid_reg || !tok_stall);
        pop  = load && final_slot;

        sent_next      = sent_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (load) begin
            out_valid_next          = 1'b1;
            out_data_next.kind      = slot_sel.kind;
            out_data_next.line      = slot_sel.line;
            out_data_next.start_res = slot_sel.start_res;
            out_data_next.length    = slot_sel.length;
            out_data_next.char_code = slot_sel.char_code;
            out_data_next.run_last  = final_slot;
            sent_next = final_slot ? '0 : (sent_reg | pick);
        end else if (!tok_stall) begin
            out_valid_next = 1'b0;
        end
    end

    // Hold the output token until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sent_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            sent_reg      <= sent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

### rtl/core/source_text_tokenizer.sv
// Top level of the source text tokenizer: front, command queue and back.
`timescale 1ns / 1ps

// Channel  Handshake              Payload                Moves
// src      src_valid / src_stall  stt_pkg::stt_in_t      one source byte per request
// tok      tok_valid / tok_stall  stt_pkg::stt_out_t     one token per request
//
// The front takes one byte per cycle while the four-entry command queue has room.
// The back sends one token per cycle while tok_stall is low; a byte that causes two or three tokens
// (pending word flush, symbol, end of text) has them sent in turn from its one queue entry.
// Reset returns line to 1 and offset to 0; the final byte does the same after its end token.
// A stalled output fills the queue; src_stall then rises until a command drains.

module source_text_tokenizer #(
    parameter int OFFSET_WIDTH = 16,
    parameter int LINE_WIDTH   = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_stall,
    input  stt_pkg::stt_in_t  src_data,
    output logic              tok_valid,
    input  logic              tok_stall,
    output stt_pkg::stt_out_t tok_data
);

    logic                        q_full, q_push, q_pop, q_head_valid;
    stt_pkg::stt_cmd_t           q_cmd, q_head_cmd;
    logic [stt_pkg::QCNT_W-1:0]  q_level;

    stt_front #(
        .OFFSET_WIDTH (OFFSET_WIDTH),
        .LINE_WIDTH   (LINE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    stt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd),
        .level      (q_level)
    );

    stt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd),
        .pop        (q_pop),
        .tok_valid  (tok_valid),
        .tok_stall  (tok_stall),
        .tok_data   (tok_data)
    );

    // End token always closes the run of its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_data.kind == stt_pkg::KIND_END |-> tok_data.run_last)
        else $error("end token without run_last");

    // End token carries no length and no character
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_data.kind == stt_pkg::KIND_END
            |-> tok_data.length == 16'd0 && tok_data.char_code == 8'd0)
        else $error("end token with length or code");

    // The final byte always leaves a command queued
    assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && !src_stall && src_data.last |=> q_level != '0)
        else $error("final byte left no command");

    // Queue never written while full
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("queue overflow");

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the source text tokenizer: byte streams checked token by token.

module tb_top;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 150;
    localparam int PHASE_BYTES = 100;

    // Tracks the tokenizer state and keeps the tokens still owed by the block
    class token_tracker;
        typedef enum logic [1:0] {SCAN_IDLE, SCAN_WORD, SCAN_NUMBER} scan_e;

        string               keyword_names[8];
        string               symbol_chars;
        logic [63:0]         keyword_words[8];
        scan_e               mode;
        logic [15:0]         tok_start;
        logic [15:0]         tok_len;
        logic [15:0]         line_no;
        logic [15:0]         offset;
        logic [63:0]         prefix;
        bit                  overflow;
        stt_pkg::stt_out_t   expected_tokens[$];
        int                  token_errors;

        function new();
            keyword_names = '{"function", "if", "while", "return",
                              "int", "float", "bool", "string"};
            symbol_chars = "+-*/=,;(){}";
            token_errors = 0;
            // pack each keyword first byte lowest
            foreach (keyword_names[k])
            begin
                keyword_words[k] = '0;
                for (int i = 0; i < keyword_names[k].len(); i++)
                    keyword_words[k][8*i +: 8] = keyword_names[k][i];
            end
            restart();
        endfunction

        function void restart();
            mode      = SCAN_IDLE;
            tok_start = '0;
            tok_len   = '0;
            prefix    = '0;
            overflow  = 1'b0;
            line_no   = 16'd1;
            offset    = '0;
        endfunction

        static function bit is_alpha(logic [7:0] c);
            return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
        endfunction

        static function bit is_digit(logic [7:0] c);
            return c >= 8'h30 && c <= 8'h39;
        endfunction

        static function bit is_space(logic [7:0] c);
            return c == stt_pkg::CH_SPACE
                   || (c >= stt_pkg::CH_TAB && c <= stt_pkg::CH_CR);
        endfunction

        // Buffer the first bytes of a word, flag anything beyond them
        function void add_word_byte(logic [7:0] c);
            if (tok_len < stt_pkg::KEYWORD_BYTES)
                prefix[8*tok_len +: 8] = c;
            else
                overflow = 1'b1;
            if (tok_len != 16'hFFFF)
                tok_len++;
        endfunction

        function void queue_token(logic [4:0] kind, logic [15:0] start, logic [15:0] len,
                                  logic [7:0] code);
            stt_pkg::stt_out_t t;
            t.kind      = kind;
            t.line      = line_no;
            t.start_res = start;
            t.length    = len;
            t.char_code = code;
            t.run_last  = 1'b0;
            expected_tokens.insert(expected_tokens.size(), t);
        endfunction

        // Close the pending word or number
        function void flush_word();
            logic [4:0] kind;
            kind = stt_pkg::KIND_NUMBER;
            if (mode == SCAN_WORD)
            begin
                kind = stt_pkg::KIND_IDENT;
                if (!overflow)
                begin
                    for (int k = 0; k < 8; k++)
                    begin
                        if (prefix == keyword_words[k])
                            kind = 5'(k);
                    end
                end
            end
            queue_token(kind, tok_start, tok_len, 8'h00);
            mode = SCAN_IDLE;
        endfunction

        // Predict the tokens caused by one accepted byte request
        function void note_source_byte(stt_pkg::stt_in_t req);
            logic [7:0] c;
            bit         taken;
            int         queued_at_entry;
            logic [4:0] kind;
            c = req.ch;
            taken = 1'b0;
            queued_at_entry = expected_tokens.size();

            // extend or close a pending word or number
            if (mode == SCAN_WORD)
            begin
                if (is_alpha(c) || is_digit(c) || c == stt_pkg::CH_UNDERSCORE)
                begin
                    add_word_byte(c);
                    taken = 1'b1;
                end
                else
                    flush_word();
            end
            else if (mode == SCAN_NUMBER)
            begin
                if (is_digit(c))
                begin
                    if (tok_len != 16'hFFFF)
                        tok_len++;
                    taken = 1'b1;
                end
                else
                    flush_word();
            end

            // handle the byte as if nothing were pending
            if (!taken)
            begin
                if (is_space(c))
                begin
                    if (c == stt_pkg::CH_NEWLINE && line_no != 16'hFFFF)
                        line_no++;
                end
                else if (is_alpha(c) || c == stt_pkg::CH_UNDERSCORE)
                begin
                    mode      = SCAN_WORD;
                    tok_start = offset;
                    tok_len   = '0;
                    prefix    = '0;
                    overflow  = 1'b0;
                    add_word_byte(c);
                end
                else if (is_digit(c))
                begin
                    mode      = SCAN_NUMBER;
                    tok_start = offset;
                    tok_len   = 16'd1;
                end
                else
                begin
                    kind = stt_pkg::KIND_UNKNOWN;
                    for (int k = 0; k < 11; k++)
                    begin
                        if (c == symbol_chars[k])
                            kind = stt_pkg::KIND_PLUS + 5'(k);
                    end
                    queue_token(kind, offset, 16'd1, c);
                end
            end

            if (offset != 16'hFFFF)
                offset++;

            // flush and close the text on its final byte
            if (req.last)
            begin
                if (mode != SCAN_IDLE)
                    flush_word();
                queue_token(stt_pkg::KIND_END, offset, 16'd0, 8'h00);
                restart();
            end

            // mark the final token of this request
            if (expected_tokens.size() > queued_at_entry)
                expected_tokens[expected_tokens.size() - 1].run_last = 1'b1;
        endfunction

        // Compare one accepted token with the oldest one owed
        function void check_token(stt_pkg::stt_out_t got);
            stt_pkg::stt_out_t want;
            if (expected_tokens.size() == 0)
            begin
                token_errors++;
                if (token_errors <= 10)
                    $display("unexpected token: k%0d l%0d s%0d n%0d c%0h r%0b",
                             got.kind, got.line, got.start_res, got.length,
                             got.char_code, got.run_last);
            end
            else
            begin
                want = expected_tokens.pop_front();
                if (got.kind !== want.kind || got.line !== want.line
                    || got.start_res !== want.start_res || got.length !== want.length
                    || got.char_code !== want.char_code || got.run_last !== want.run_last)
                begin
                    token_errors++;
                    if (token_errors <= 10)
                        $display("token mismatch: expected k%0d l%0d s%0d n%0d c%0h r%0b",
                                 want.kind, want.line, want.start_res, want.length,
                                 want.char_code, want.run_last,
                                 "  got k%0d l%0d s%0d n%0d c%0h r%0b",
                                 got.kind, got.line, got.start_res, got.length,
                                 got.char_code, got.run_last);
                end
            end
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               src_valid = 1'b0;
    logic               src_stall;
    stt_pkg::stt_in_t   src_data  = '0;
    logic               tok_valid;
    logic               tok_stall = 1'b0;
    stt_pkg::stt_out_t  tok_data;

    int        src_idle_pct  = 0;
    int        sink_idle_pct = 0;
    bit        hold_go       = 1'b0;
    bit        hold_armed    = 1'b0;
    int        hold_left     = 0;
    int        cycle_count   = 0;
    int        bytes_sent    = 0;
    string     word_chars =
        "_abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
    token_tracker tracker;

    source_text_tokenizer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_data  (tok_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Drive the output stall: random gaps, plus one long hold once requested
    always @(negedge clk)
    begin
        if (hold_go && !hold_armed)
        begin
            hold_armed <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            tok_stall  <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            tok_stall <= 1'b1;
        end
        else
            tok_stall <= ($urandom_range(0, 99) < sink_idle_pct);
    end

    // Check every accepted token
    always @(posedge clk)
    begin
        if (rst_n && tok_valid === 1'b1 && tok_stall == 1'b0)
            tracker.check_token(tok_data);
    end

    // Offer one byte request, idle at random first, hold it until accepted
    task automatic send_byte(input logic [7:0] c, input logic is_last);
        stt_pkg::stt_in_t req;
        req.ch   = c;
        req.last = is_last;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            src_valid <= 1'b0;
            @(negedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= req;
        do
            @(posedge clk);
        while (src_stall !== 1'b0);
        tracker.note_source_byte(req);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    // Build one text from random pieces and send it, final byte flagged
    task automatic send_random_text();
        logic [7:0] text[$];
        string      w;
        int         pieces;
        pieces = $urandom_range(3, 14);
        repeat (pieces)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    w = tracker.keyword_names[$urandom_range(0, 7)];
                    for (int i = 0; i < w.len(); i++)
                        text.insert(text.size(), w[i]);
                end
                2:
                begin
                    // near miss: clipped keyword, or keyword with a tail
                    w = tracker.keyword_names[$urandom_range(0, 7)];
                    if ($urandom_range(0, 1))
                    begin
                        for (int i = 0; i < w.len() - 1; i++)
                            text.insert(text.size(), w[i]);
                    end
                    else
                    begin
                        for (int i = 0; i < w.len(); i++)
                            text.insert(text.size(), w[i]);
                        repeat ($urandom_range(1, 2))
                            text.insert(text.size(), word_chars[$urandom_range(0, 62)]);
                    end
                end
                3:
                begin
                    text.insert(text.size(), word_chars[$urandom_range(0, 52)]);
                    repeat ($urandom_range(0, 10))
                        text.insert(text.size(), word_chars[$urandom_range(0, 62)]);
                end
                4:
                begin
                    repeat ($urandom_range(1, 5))
                        text.insert(text.size(), 8'h30 + 8'($urandom_range(0, 9)));
                end
                5, 6: text.insert(text.size(), tracker.symbol_chars[$urandom_range(0, 10)]);
                7:
                begin
                    if ($urandom_range(0, 1))
                        text.insert(text.size(), stt_pkg::CH_SPACE);
                    else
                        text.insert(text.size(), stt_pkg::CH_TAB + 8'($urandom_range(0, 4)));
                end
                8: text.insert(text.size(), 8'($urandom_range(0, 255)));
                default: text.insert(text.size(), stt_pkg::CH_NEWLINE);
            endcase
            if ($urandom_range(0, 1))
                text.insert(text.size(), stt_pkg::CH_SPACE);
        end
        foreach (text[i])
            send_byte(text[i], i == text.size() - 1);
    endtask

    task automatic run_random_phase(input int n_bytes);
        int phase_start;
        phase_start = bytes_sent;
        while (bytes_sent - phase_start < n_bytes)
            send_random_text();
    endtask

    initial
    begin
        int settle;
        tracker = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: keyword, symbols, word, newline, flushes on the final byte, unknown bytes
        send_text("function(x_9)\n");
        send_text("a+");
        send_text("7");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);

        // random texts under three idle patterns
        src_idle_pct = 18;
        sink_idle_pct <= 75;
        run_random_phase(PHASE_BYTES);
        src_idle_pct = 75;
        sink_idle_pct <= 18;
        run_random_phase(PHASE_BYTES);
        src_idle_pct = 0;
        sink_idle_pct <= 0;
        hold_go <= 1'b1;
        run_random_phase(PHASE_BYTES);

        // keyword then a number flushed by the final byte
        send_text("if 7");
        src_valid <= 1'b0;

        // drain the tokens still owed, then let the block settle
        for (settle = 0; settle < 20000 && tracker.expected_tokens.size() != 0; settle++)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (tracker.token_errors == 0 && tracker.expected_tokens.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
rtl/core/stt_pkg.sv
rtl/core/stt_front.sv
rtl/core/stt_queue.sv
rtl/core/stt_back.sv
rtl/core/source_text_tokenizer.sv
test/tb_top.sv
